// ===== design/mpd_pkg.sv =====
// Shared types, codes and constants of the mouse packet decoder.
package mpd_pkg;

    // Screen size; the pointer starts in the middle after reset.
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam logic [11:0] POS_X_RESET = 12'((SCREEN_WIDTH / 2) % 4096);
    localparam logic [11:0] POS_Y_RESET = 12'((SCREEN_HEIGHT / 2) % 4096);

    // Protocol codes; the unused code behaves as plain PS/2.
    localparam logic [1:0] PROTO_PS2    = 2'd0;
    localparam logic [1:0] PROTO_WHEEL  = 2'd1;
    localparam logic [1:0] PROTO_SERIAL = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_PROTOCOL = 3'd0;
    localparam logic [2:0] REG_X_LOW    = 3'd1;
    localparam logic [2:0] REG_X_HIGH   = 3'd2;
    localparam logic [2:0] REG_Y_LOW    = 3'd3;
    localparam logic [2:0] REG_Y_HIGH   = 3'd4;

    // Header and field masks of the byte formats.
    localparam logic [7:0] PS2_HDR_MASK   = 8'hC0;
    localparam logic [7:0] SER_HDR_MASK   = 8'h40;
    localparam logic [7:0] SER_MID_CODE   = 8'h40;
    localparam logic [7:0] PS2_X_SIGN     = 8'h10;
    localparam logic [7:0] PS2_Y_SIGN     = 8'h20;
    localparam logic [7:0] SER_LEFT       = 8'h20;
    localparam logic [7:0] SER_RIGHT      = 8'h10;
    localparam logic [7:0] WHEEL_UP       = 8'h80;
    localparam logic [7:0] SER_LOW_BITS   = 8'h3F;
    localparam logic [7:0] SER_X_HIGH     = 8'h03;
    localparam logic [7:0] SER_Y_HIGH     = 8'h0C;

    // Event slots per packet: scroll, three buttons, motion.
    localparam int EVT_SLOTS = 5;
    localparam int SLOT_W    = 3;

    typedef enum logic [2:0] {
        EV_MOTION      = 3'd0,
        EV_PRESS       = 3'd1,
        EV_RELEASE     = 3'd2,
        EV_SCROLL_UP   = 3'd3,
        EV_SCROLL_DOWN = 3'd4
    } evt_kind_t;

    typedef struct packed {
        evt_kind_t   kind;
        logic [1:0]  button;
        logic [11:0] x;
        logic [11:0] y;
        logic [2:0]  mask;
        logic        last;
    } evt_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] fourth;
    } pkt_t;

    typedef struct packed {
        logic [1:0]  protocol;
        logic [11:0] x_low;
        logic [11:0] x_high;
        logic [11:0] y_low;
        logic [11:0] y_high;
    } cfg_t;

endpackage

// ===== design/mpd_assembler.sv =====
// Input register, header sync and packet assembly.
module mpd_assembler
    import mpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // rx_byte[7:0]
    input  cfg_t       cfg,
    input  logic       evb_ready,   // event buffer can take a packet's events
    output logic       pkt_fire,    // a packet completes this cycle
    output pkt_t       pkt
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [1:0] byte_count_reg;
    logic [1:0] byte_count_next;
    logic [7:0] pkt_bytes_reg [3];

    logic       serial;
    logic       wheel;
    logic       is_header;
    logic       dropped;
    logic       store;
    logic       completes;
    logic       consume;
    logic [2:0] pkt_size;

    // Decide what the byte in the input register does.
    always_comb begin
        serial    = (cfg.protocol == PROTO_SERIAL);
        wheel     = (cfg.protocol == PROTO_WHEEL);
        pkt_size  = wheel ? 3'd4 : 3'd3;
        is_header = serial ? ((in_byte_reg & SER_HDR_MASK) == SER_HDR_MASK)
                           : ((in_byte_reg & PS2_HDR_MASK) == 8'h00);
        dropped   = (byte_count_reg == 2'd0) && !is_header;
        store     = !dropped && (({1'b0, byte_count_reg} + 3'd1) < pkt_size);
        completes = !dropped && !store;
        consume   = in_valid_reg && (!completes || evb_ready);
        pkt_fire  = consume && completes;
        s_tready  = !in_valid_reg || consume;

        byte_count_next = byte_count_reg;
        if (store) begin
            byte_count_next = byte_count_reg + 2'd1;
        end else if (completes) begin
            byte_count_next = 2'd0;
        end
    end

    // Complete packet with the incoming byte merged in.
    always_comb begin
        pkt.b0     = pkt_bytes_reg[0];
        pkt.b1     = pkt_bytes_reg[1];
        pkt.b2     = wheel ? pkt_bytes_reg[2] : in_byte_reg;
        pkt.fourth = wheel ? in_byte_reg : 8'h00;
    end

    // Control state: input register occupancy and byte count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            byte_count_reg <= 2'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (consume) begin
                byte_count_reg <= byte_count_next;
            end
        end
    end

    // Payload: input byte and stored packet bytes.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (consume && store) begin
            unique case (byte_count_reg)
                2'd0:    pkt_bytes_reg[0] <= in_byte_reg;
                2'd1:    pkt_bytes_reg[1] <= in_byte_reg;
                default: pkt_bytes_reg[2] <= in_byte_reg;
            endcase
        end else if (consume && completes && !wheel) begin
            pkt_bytes_reg[2] <= in_byte_reg;
        end
    end

endmodule

// ===== design/mpd_event_gen.sv =====
// Packet decoding, button and position state, and event candidates.
module mpd_event_gen
    import mpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  logic                 pkt_fire,
    input  pkt_t                 pkt,
    output evt_t                 cand [EVT_SLOTS],
    output logic [EVT_SLOTS-1:0] cand_valid
);

    logic [2:0]  held_reg;
    logic [2:0]  serial_prev_reg;
    logic [2:0]  serial_prev_next;
    logic [11:0] pos_x_reg;
    logic [11:0] pos_y_reg;
    logic [11:0] pos_x_next;
    logic [11:0] pos_y_next;

    logic        serial;
    logic        wheel;
    logic        quirk;
    logic        l_btn;
    logic        m_btn;
    logic        r_btn;
    logic [7:0]  ux;
    logic [7:0]  uy;
    logic [9:0]  dx;
    logic [9:0]  dy;
    logic [9:0]  dy_raw;
    logic [2:0]  newb;
    logic [2:0]  cur_mask;

    // Add a delta and clamp; the low limit is tested first, then the high one.
    function automatic logic [11:0] clamp_axis(input logic [11:0] pos,
                                               input logic [9:0]  delta,
                                               input logic [11:0] lo,
                                               input logic [11:0] hi);
        logic signed [13:0] sum;
        logic [11:0]        res;
        sum = $signed({2'b00, pos}) + $signed({{4{delta[9]}}, delta});
        if (sum < $signed({2'b00, lo})) begin
            res = lo;
        end else if (sum > $signed({2'b00, hi})) begin
            res = hi;
        end else begin
            res = sum[11:0];
        end
        return res;
    endfunction

    // Decode buttons and deltas of the packet.
    always_comb begin
        serial           = (cfg.protocol == PROTO_SERIAL);
        wheel            = (cfg.protocol == PROTO_WHEEL);
        quirk            = (pkt.b0 == SER_MID_CODE)
                           && (({5'b0, serial_prev_reg} | pkt.b1 | pkt.b2) == 8'h00);
        l_btn            = quirk ? 1'b0 : ((pkt.b0 & SER_LEFT) != 8'h00);
        m_btn            = quirk;
        r_btn            = quirk ? 1'b0 : ((pkt.b0 & SER_RIGHT) != 8'h00);
        ux               = ((pkt.b0 & SER_X_HIGH) << 6) | (pkt.b1 & SER_LOW_BITS);
        uy               = ((pkt.b0 & SER_Y_HIGH) << 4) | (pkt.b2 & SER_LOW_BITS);
        serial_prev_next = serial_prev_reg;
        dy_raw           = {{2{(pkt.b0 & PS2_Y_SIGN) != 8'h00}}, pkt.b2};
        if (serial) begin
            serial_prev_next = {l_btn, m_btn, r_btn};
            newb             = {r_btn, m_btn, l_btn};
            dx               = {{2{ux[7]}}, ux};
            dy               = {{2{uy[7]}}, uy};
        end else begin
            newb = {pkt.b0[1], pkt.b0[2], pkt.b0[0]};
            dx   = (pkt.b1 != 8'h00)
                   ? {{2{(pkt.b0 & PS2_X_SIGN) != 8'h00}}, pkt.b1} : 10'd0;
            dy   = (pkt.b2 != 8'h00) ? (10'd0 - dy_raw) : 10'd0;
        end
        pos_x_next = clamp_axis(pos_x_reg, dx, cfg.x_low, cfg.x_high);
        pos_y_next = clamp_axis(pos_y_reg, dy, cfg.y_low, cfg.y_high);
    end

    // Event candidates in emission order: scroll, buttons 1 to 3, motion.
    always_comb begin
        cand[0].kind   = ((pkt.fourth & WHEEL_UP) != 8'h00) ? EV_SCROLL_UP
                                                            : EV_SCROLL_DOWN;
        cand[0].button = 2'd0;
        cand[0].x      = pos_x_reg;
        cand[0].y      = pos_y_reg;
        cand[0].mask   = held_reg;
        cand[0].last   = 1'b0;
        cand_valid[0]  = wheel && (pkt.fourth != 8'h00);

        cur_mask = held_reg;
        for (int i = 0; i < 3; i++) begin
            cur_mask[i]        = newb[i];
            cand[i+1].kind     = newb[i] ? EV_PRESS : EV_RELEASE;
            cand[i+1].button   = 2'(i + 1);
            cand[i+1].x        = pos_x_reg;
            cand[i+1].y        = pos_y_reg;
            cand[i+1].mask     = cur_mask;
            cand[i+1].last     = 1'b0;
            cand_valid[i+1]    = (newb[i] != held_reg[i]);
        end

        cand[4].kind   = EV_MOTION;
        cand[4].button = 2'd0;
        cand[4].x      = pos_x_next;
        cand[4].y      = pos_y_next;
        cand[4].mask   = newb;
        cand[4].last   = 1'b0;
        cand_valid[4]  = (dx != 10'd0) || (dy != 10'd0);
    end

    // Button and pointer state, updated once per packet.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg        <= 3'd0;
            serial_prev_reg <= 3'd0;
            pos_x_reg       <= POS_X_RESET;
            pos_y_reg       <= POS_Y_RESET;
        end else if (pkt_fire) begin
            held_reg        <= newb;
            serial_prev_reg <= serial_prev_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
        end
    end

endmodule

// ===== design/mpd_event_buffer.sv =====
// Event buffer: packs a packet's events, sends one beat a cycle while m_tready.
module mpd_event_buffer
    import mpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pkt_fire,
    input  evt_t                 cand [EVT_SLOTS],
    input  logic [EVT_SLOTS-1:0] cand_valid,
    output logic                 evb_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // button_number, pointer_x, pointer_y,
                                            // button_mask, zero fill
    output logic [2:0]           m_tuser,   // event_kind
    output logic                 m_tlast    // last_of_packet
);

    evt_t              evt_mem_reg [EVT_SLOTS];
    logic              buf_valid_reg;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [SLOT_W-1:0] slot [EVT_SLOTS];
    logic [SLOT_W-1:0] total;
    evt_t              cand_tagged [EVT_SLOTS];
    evt_t              cur;
    logic              take;
    logic              take_last;

    // Position of each valid candidate among the valid ones; the final one
    // carries the last flag.
    always_comb begin
        total = '0;
        for (int c = 0; c < EVT_SLOTS; c++) begin
            slot[c] = total;
            total   = total + SLOT_W'(cand_valid[c]);
        end
        for (int c = 0; c < EVT_SLOTS; c++) begin
            cand_tagged[c]      = cand[c];
            cand_tagged[c].last = (slot[c] == total - SLOT_W'(1));
        end
    end

    assign cur       = evt_mem_reg[rd_idx_reg];
    assign m_tvalid  = buf_valid_reg;
    assign m_tdata   = {3'b000, cur.mask, cur.y, cur.x, cur.button};
    assign m_tuser   = cur.kind;
    assign m_tlast   = cur.last;
    assign take      = buf_valid_reg && m_tready;
    assign take_last = take && cur.last;
    assign evb_ready = !buf_valid_reg || take_last;

    // Buffer occupancy and read pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
        end else if (pkt_fire) begin
            buf_valid_reg <= (total != '0);
            rd_idx_reg    <= '0;
        end else if (take) begin
            if (take_last) begin
                buf_valid_reg <= 1'b0;
            end else begin
                rd_idx_reg <= rd_idx_reg + SLOT_W'(1);
            end
        end
    end

    // Packed event storage.
    always_ff @(posedge aclk) begin
        if (pkt_fire) begin
            for (int c = 0; c < EVT_SLOTS; c++) begin
                if (cand_valid[c]) begin
                    evt_mem_reg[slot[c]] <= cand_tagged[c];
                end
            end
        end
    end

endmodule

// ===== design/mouse_packet_decoder_unit.sv =====
// Top level of the mouse packet decoder: configuration registers and wiring.
//
// Raw mouse bytes enter on the s_ stream, one byte per beat. Bytes are
// gathered into PS/2, wheel PS/2 or Microsoft serial packets after a valid
// header byte; other bytes between packets are discarded. Each finished
// packet gives zero to five events on the m_ stream, in order: scroll,
// button changes for buttons 1 to 3, then motion; tuser carries the event
// kind and tlast marks the final one.
// The configuration channel writes protocol and clamp limits by index and
// is always ready; write it only while the block is idle.
// The first event of a packet is presented on the cycle after its finishing
// byte leaves the input register; the remaining events follow one per cycle
// while m_tready is high. Bytes that do not finish a packet are taken every
// cycle. A finishing byte waits in the input register until the previous
// packet's last event is taken; a stalled receiver holds its current event
// steady, and s_tready drops once that finishing byte is held.
// Reset clears all control state, releases all buttons and centres the
// pointer on the screen.
module mouse_packet_decoder_unit
    import mpd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // button_number[1:0], pointer_x[13:2], pointer_y[25:14],
                                    // button_mask[28:26], zero fill[31:29]
    output logic [2:0]  m_tuser,    // event_kind[2:0]
    output logic        m_tlast,    // last_of_packet
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    cfg_t                 cfg_reg;
    logic                 evb_ready;
    logic                 pkt_fire;
    pkt_t                 pkt;
    evt_t                 cand [EVT_SLOTS];
    logic [EVT_SLOTS-1:0] cand_valid;

    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.protocol <= PROTO_PS2;
            cfg_reg.x_low    <= 12'd0;
            cfg_reg.x_high   <= 12'd1023;
            cfg_reg.y_low    <= 12'd0;
            cfg_reg.y_high   <= 12'd767;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PROTOCOL: cfg_reg.protocol <= cfg_data[1:0];
                REG_X_LOW:    cfg_reg.x_low    <= cfg_data;
                REG_X_HIGH:   cfg_reg.x_high   <= cfg_data;
                REG_Y_LOW:    cfg_reg.y_low    <= cfg_data;
                REG_Y_HIGH:   cfg_reg.y_high   <= cfg_data;
                default: ;
            endcase
        end
    end

    mpd_assembler u_assembler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg       (cfg_reg),
        .evb_ready (evb_ready),
        .pkt_fire  (pkt_fire),
        .pkt       (pkt)
    );

    mpd_event_gen u_event_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .pkt_fire   (pkt_fire),
        .pkt        (pkt),
        .cand       (cand),
        .cand_valid (cand_valid)
    );

    mpd_event_buffer u_event_buffer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pkt_fire   (pkt_fire),
        .cand       (cand),
        .cand_valid (cand_valid),
        .evb_ready  (evb_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== sim/mouse_packet_decoder_unit_tb.sv =====
// Self-checking testbench of the mouse packet decoder unit.
`timescale 1ns / 100ps

module mouse_packet_decoder_unit_tb;
    import mpd_pkg::*;

    // The spare protocol code, which the block treats as plain PS/2.
    localparam logic [1:0] PROTO_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BYTES   = 20;

    typedef struct {
        evt_kind_t   kind;
        logic [1:0]  button;
        logic [11:0] x;
        logic [11:0] y;
        logic [2:0]  mask;
        logic        last;
    } mouse_event_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // rx_byte[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // button_number[1:0], pointer_x[13:2], pointer_y[25:14],
                               // button_mask[28:26], zero fill[31:29]
    logic [2:0]  m_tuser;      // event_kind[2:0]
    logic        m_tlast;      // last_of_packet
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    // Predicted decoder state and its copy of the registers.
    logic [1:0]  cfg_proto;
    int          x_lo, x_hi, y_lo, y_hi;
    logic [7:0]  stored_bytes [0:2];
    int          stored_count;
    logic [2:0]  held;
    logic [2:0]  serial_prev;
    int          pos_x, pos_y;

    mouse_event_t expected_events [$];
    bit           no_idle;
    int           errors = 0;
    int           bytes_sent = 0;
    int           events_checked = 0;
    int           cycle_count = 0;

    mouse_packet_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock of 8 ns.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("mouse_packet_decoder_unit_tb failed");
            $finish;
        end
    end

    // The receiver stalls with a probability of 30 percent unless idling is off.
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
    end

    // Works out the events that one accepted byte causes and queues them.
    function automatic void decode_byte(input logic [7:0] rx);
        mouse_event_t evs [0:4];
        evt_kind_t    k;
        logic [7:0]   b0, b1, b2, fourth, ux, uy;
        logic [2:0]   newb;
        logic         is_serial, is_wheel, hdr;
        int           pkt_len, dx, dy, n, nx, ny, i;

        is_serial = (cfg_proto == PROTO_SERIAL);
        is_wheel  = (cfg_proto == PROTO_WHEEL);
        pkt_len   = is_wheel ? 4 : 3;
        n         = 0;
        fourth    = 8'h00;

        // Between packets only a header byte is taken; the rest are dropped.
        if (stored_count == 0) begin
            hdr = is_serial ? ((rx & SER_HDR_MASK) == SER_HDR_MASK)
                            : ((rx & PS2_HDR_MASK) == 8'h00);
            if (!hdr)
                return;
        end
        if (stored_count + 1 < pkt_len) begin
            stored_bytes[stored_count] = rx;
            stored_count++;
            return;
        end
        if (is_wheel)
            fourth = rx;
        else
            stored_bytes[2] = rx;
        stored_count = 0;
        b0 = stored_bytes[0];
        b1 = stored_bytes[1];
        b2 = stored_bytes[2];

        if (is_serial) begin
            // A bare 0x40 packet after no buttons means the middle button.
            if (b0 == SER_MID_CODE && (serial_prev | b1 | b2) == 8'h00)
                newb = 3'b010;
            else
                newb = {b0[4], 1'b0, b0[5]};
            serial_prev = {newb[0], newb[1], newb[2]};
            ux = {b0[1:0], b1[5:0]};
            uy = {b0[3:2], b2[5:0]};
            dx = int'($signed(ux));
            dy = int'($signed(uy));
        end else begin
            newb = {b0[1], b0[2], b0[0]};
            dx = (b1 == 8'h00) ? 0 : (b0[4] ? int'(b1) - 256 : int'(b1));
            dy = (b2 == 8'h00) ? 0 : -(b0[5] ? int'(b2) - 256 : int'(b2));
            if (is_wheel && fourth != 8'h00) begin
                if (fourth[7])
                    k = EV_SCROLL_UP;
                else
                    k = EV_SCROLL_DOWN;
                evs[n] = '{k, 2'd0, 12'(pos_x), 12'(pos_y), held, 1'b0};
                n++;
            end
        end

        // One press or release per changed button, each with the mask after it.
        for (i = 0; i < 3; i++) begin
            if (newb[i] != held[i]) begin
                held[i] = newb[i];
                if (newb[i])
                    k = EV_PRESS;
                else
                    k = EV_RELEASE;
                evs[n] = '{k, 2'(i + 1), 12'(pos_x), 12'(pos_y), held, 1'b0};
                n++;
            end
        end

        // Low limit first; crossed limits give the low one only for a sum below it.
        nx = pos_x + dx;
        if (nx < x_lo)
            nx = x_lo;
        else if (nx > x_hi)
            nx = x_hi;
        ny = pos_y + dy;
        if (ny < y_lo)
            ny = y_lo;
        else if (ny > y_hi)
            ny = y_hi;
        pos_x = nx;
        pos_y = ny;

        if (dx != 0 || dy != 0) begin
            evs[n] = '{EV_MOTION, 2'd0, 12'(pos_x), 12'(pos_y), held, 1'b0};
            n++;
        end
        if (n > 0)
            evs[n - 1].last = 1'b1;
        for (i = 0; i < n; i++)
            expected_events.push_back(evs[i]);
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Every event beat is checked against the oldest predicted event.
    always @(posedge aclk) begin
        mouse_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected event beat, expected none, actual tdata %h tuser %h tlast %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_events.pop_front();
                compare_field("event_kind", int'(want.kind), int'(m_tuser[2:0]));
                compare_field("button_number", int'(want.button), int'(m_tdata[1:0]));
                compare_field("pointer_x", int'(want.x), int'(m_tdata[13:2]));
                compare_field("pointer_y", int'(want.y), int'(m_tdata[25:14]));
                compare_field("button_mask", int'(want.mask), int'(m_tdata[28:26]));
                compare_field("last_of_packet", int'(want.last), int'(m_tlast));
                events_checked++;
            end
        end
    end

    // Sends one mouse byte, with random gaps before it, and predicts its events.
    task automatic send_byte(input logic [7:0] value);
        while (!no_idle && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        decode_byte(value);
        bytes_sent++;
    endtask

    // Waits until every predicted event has arrived and the input stage is empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes one register; the valid is left high for a following write.
    task automatic write_reg(input logic [2:0] idx, input logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PROTOCOL: cfg_proto = value[1:0];
            REG_X_LOW:    x_lo = int'(value);
            REG_X_HIGH:   x_hi = int'(value);
            REG_Y_LOW:    y_lo = int'(value);
            REG_Y_HIGH:   y_hi = int'(value);
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [1:0] proto, input logic [11:0] xl,
                                input logic [11:0] xh, input logic [11:0] yl,
                                input logic [11:0] yh);
        settle();
        write_reg(REG_PROTOCOL, 12'(proto));
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        cfg_valid <= 1'b0;
    endtask

    // Plain PS/2: a dropped non-header byte, all buttons down with the largest
    // positive deltas, then all up with the largest negative deltas.
    task automatic test_ps2();
        program_regs(PROTO_PS2, 12'd0, 12'd1023, 12'd0, 12'd767);
        send_byte(8'hC0);
        send_byte(8'h0F); send_byte(8'h7F); send_byte(8'h7F);
        send_byte(8'h38); send_byte(8'h80); send_byte(8'h80);
    endtask

    // Wheel PS/2 with a five-event packet, a scroll down with releases, then a
    // protocol change to the spare code mid-packet that ends in a silent packet.
    task automatic test_wheel_and_switch();
        program_regs(PROTO_WHEEL, 12'd0, 12'd1023, 12'd0, 12'd767);
        send_byte(8'h0F); send_byte(8'h01); send_byte(8'h01); send_byte(8'h80);
        send_byte(8'h08); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
        send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
        settle();
        write_reg(REG_PROTOCOL, 12'(PROTO_SPARE));
        cfg_valid <= 1'b0;
        send_byte(8'h00);
    endtask

    // Serial: a dropped byte, the middle-button code, then a header with bit 7
    // set whose deltas ignore the top bits of the data bytes.
    task automatic test_serial();
        program_regs(PROTO_SERIAL, 12'd0, 12'd1023, 12'd0, 12'd767);
        send_byte(8'h80);
        send_byte(SER_MID_CODE); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hCF); send_byte(8'hBF); send_byte(8'hBF);
    endtask

    // Crossed limits, where the low one wins, and limits pinned at the extremes.
    task automatic test_limits();
        program_regs(PROTO_PS2, 12'd3000, 12'd100, 12'd4095, 12'd0);
        send_byte(8'h08); send_byte(8'h01); send_byte(8'h01);
        program_regs(PROTO_PS2, 12'd4095, 12'd4095, 12'd0, 12'd0);
        send_byte(8'h38); send_byte(8'hFF); send_byte(8'h01);
    endtask

    // Phases of random settings, mostly well-formed packets with random content
    // and some stray bytes; one phase runs with no idling on either side.
    task automatic test_random();
        int          phase, sent, r, pkt_len, i;
        logic [1:0]  proto;
        logic [11:0] xl, xh, yl, yh;

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            proto = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0: begin
                    xl = 12'd0;
                    xh = 12'hFFF;
                    yl = 12'd0;
                    yh = 12'hFFF;
                end
                1: begin
                    xl = 12'($urandom_range(0, 4095));
                    xh = 12'($urandom_range(0, 4095));
                    yl = 12'($urandom_range(0, 4095));
                    yh = 12'($urandom_range(0, 4095));
                end
                default: begin
                    xl = 12'($urandom_range(0, 300));
                    xh = 12'($urandom_range(700, 4095));
                    yl = 12'($urandom_range(0, 300));
                    yh = 12'($urandom_range(500, 4095));
                end
            endcase
            program_regs(proto, xl, xh, yl, yh);
            no_idle = (phase == 3);
            pkt_len = (proto == PROTO_WHEEL) ? 4 : 3;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    send_byte(8'($urandom));
                end else if (r < 20 && proto == PROTO_SERIAL) begin
                    send_byte(SER_MID_CODE); send_byte(8'h00); send_byte(8'h00);
                    sent += 3;
                end else begin
                    if (proto == PROTO_SERIAL)
                        send_byte(8'($urandom) | SER_HDR_MASK);
                    else
                        send_byte(8'($urandom) & ~PS2_HDR_MASK);
                    for (i = 1; i < pkt_len; i++)
                        send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
                    sent += pkt_len;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_PROTOCOL;
        cfg_data  = 12'd0;
        no_idle   = 1'b0;

        // State after reset.
        cfg_proto    = PROTO_PS2;
        x_lo         = 0;
        x_hi         = 1023;
        y_lo         = 0;
        y_hi         = 767;
        stored_bytes = '{8'h00, 8'h00, 8'h00};
        stored_count = 0;
        held         = 3'b000;
        serial_prev  = 3'b000;
        pos_x        = int'(POS_X_RESET);
        pos_y        = int'(POS_Y_RESET);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_ps2();
        test_wheel_and_switch();
        test_serial();
        test_limits();
        test_random();
        settle();

        $display("Run covered %0d mouse bytes and %0d checked event beats", bytes_sent,
                 events_checked);
        $display("over all protocol codes, mid-packet protocol changes and crossed limits.");
        if (errors == 0)
            $display("mouse_packet_decoder_unit_tb passed");
        else
            $display("mouse_packet_decoder_unit_tb failed");
        $finish;
    end

endmodule
